@@ sv/psnd_pkg.sv @@
`default_nettype none
package psnd_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned DIFF_W      = COORD_W + 1;
  localparam int unsigned PROD_W      = 2 * DIFF_W;
  localparam int unsigned NUM_W       = PROD_W + 1;
  localparam int unsigned DEN_W       = PROD_W;
  localparam int unsigned T_FRAC      = 16;
  localparam int unsigned DIST_W      = COORD_W + 1;
  localparam int unsigned SQ_W        = 2 * DIST_W;
  localparam int unsigned TOL_W       = 8;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;
  localparam int unsigned DIV_STAGES  = T_FRAC;
  localparam int unsigned SQRT_STAGES = DIST_W;

  localparam logic REG_TOL = 1'b0;

  typedef enum logic [1:0] {
    CASE_INTERIOR = 2'd0,
    CASE_START    = 2'd1,
    CASE_END      = 2'd2,
    CASE_DEGEN    = 2'd3
  } case_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    case_e                     code;
  } geo_side_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    case_e                     code;
  } near_side_t;

endpackage
`default_nettype wire

@@ sv/psnd_if.sv @@
`default_nettype none
interface psnd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [psnd_pkg::COORD_W-1:0] point_x;
  logic signed [psnd_pkg::COORD_W-1:0] point_y;
  logic signed [psnd_pkg::COORD_W-1:0] seg_a_x;
  logic signed [psnd_pkg::COORD_W-1:0] seg_a_y;
  logic signed [psnd_pkg::COORD_W-1:0] seg_b_x;
  logic signed [psnd_pkg::COORD_W-1:0] seg_b_y;

  modport source (output valid, point_x, point_y, seg_a_x, seg_a_y, seg_b_x, seg_b_y,
                  input ready);
  modport sink   (input valid, point_x, point_y, seg_a_x, seg_a_y, seg_b_x, seg_b_y,
                  output ready);
endinterface

interface psnd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [psnd_pkg::COORD_W-1:0] near_x;
  logic signed [psnd_pkg::COORD_W-1:0] near_y;
  logic        [psnd_pkg::DIST_W-1:0]  distance;
  logic        [1:0]                   case_code;

  modport source (output valid, near_x, near_y, distance, case_code, input ready);
  modport sink   (input valid, near_x, near_y, distance, case_code, output ready);
endinterface
`default_nettype wire

@@ sv/psnd_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per stage, num < den expected
module psnd_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [psnd_pkg::DEN_W-1:0]     num_i,
  input  logic [psnd_pkg::DEN_W-1:0]     den_i,
  output logic [psnd_pkg::T_FRAC-1:0]    quo_o
);

  logic [psnd_pkg::DEN_W-1:0]  rem_q [psnd_pkg::DIV_STAGES];
  logic [psnd_pkg::DEN_W-1:0]  den_q [psnd_pkg::DIV_STAGES];
  logic [psnd_pkg::T_FRAC-1:0] quo_q [psnd_pkg::DIV_STAGES];

  for (genvar k = 0; k < psnd_pkg::DIV_STAGES; k++) begin : g_stage
    logic [psnd_pkg::DEN_W-1:0]  r_in;
    logic [psnd_pkg::DEN_W-1:0]  d_in;
    logic [psnd_pkg::T_FRAC-1:0] q_in;
    logic [psnd_pkg::DEN_W:0]    r2;
    logic [psnd_pkg::DEN_W:0]    diff;
    logic                        take;

    if (k == 0) begin : g_first
      assign r_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
      assign q_in = quo_q[k-1];
    end

    assign r2   = {r_in, 1'b0};
    assign diff = r2 - {1'b0, d_in};
    assign take = (r2 >= {1'b0, d_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? diff[psnd_pkg::DEN_W-1:0] : r2[psnd_pkg::DEN_W-1:0];
        den_q[k] <= d_in;
        quo_q[k] <= {q_in[psnd_pkg::T_FRAC-2:0], take};
      end
    end
  end

  assign quo_o = quo_q[psnd_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

@@ sv/psnd_sqrt.sv @@
`default_nettype none
// digit-by-digit floor square root, one root bit per stage
module psnd_sqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [psnd_pkg::SQ_W-1:0]   sq_i,
  output logic [psnd_pkg::DIST_W-1:0] root_o
);

  localparam int unsigned REM_W = psnd_pkg::DIST_W + 3;

  logic [psnd_pkg::SQ_W-1:0]   rad_q  [psnd_pkg::SQRT_STAGES];
  logic [REM_W-1:0]            rem_q  [psnd_pkg::SQRT_STAGES];
  logic [psnd_pkg::DIST_W-1:0] root_q [psnd_pkg::SQRT_STAGES];

  for (genvar k = 0; k < psnd_pkg::SQRT_STAGES; k++) begin : g_stage
    logic [psnd_pkg::SQ_W-1:0]   rad_in;
    logic [REM_W-1:0]            rem_in;
    logic [psnd_pkg::DIST_W-1:0] root_in;
    logic [REM_W-1:0]            rem_sh;
    logic [REM_W-1:0]            trial;
    logic                        take;

    if (k == 0) begin : g_first
      assign rad_in  = sq_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down the next bit pair
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[psnd_pkg::SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[psnd_pkg::SQ_W-3:0], 2'b00};
        rem_q[k]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[psnd_pkg::DIST_W-2:0], take};
      end
    end
  end

  assign root_o = root_q[psnd_pkg::SQRT_STAGES-1];

endmodule
`default_nettype wire

@@ sv/point_segment_nearest_distance.sv @@
`default_nettype none
// Nearest point on a segment and the distance to it, signed Q8.8 coordinates.
// Fully pipelined: one transfer per cycle in and out unless stalled
// (3 setup stages, 16 divider stages for the projection parameter, 5 stages
// for interpolation and squared distance, 17 square-root stages). A stall at
// the output freezes the whole pipe; nothing is dropped. coincide_tolerance
// sits at byte address 0 of the APB port and should be written while idle.
module point_segment_nearest_distance (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [psnd_pkg::PADDR_W-1:0]   paddr,
  input  logic [psnd_pkg::PDATA_W-1:0]   pwdata,
  output logic [psnd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  psnd_in_if.sink                        in_i,
  psnd_out_if.source                     out_o
);

  localparam int unsigned S3   = 2;
  localparam int unsigned S4   = 3 + psnd_pkg::DIV_STAGES;
  localparam int unsigned S5   = S4 + 1;
  localparam int unsigned S7   = S4 + 3;
  localparam int unsigned S8   = S4 + 4;
  localparam int unsigned NSTG = S8 + 1 + psnd_pkg::SQRT_STAGES;
  localparam int unsigned CW   = psnd_pkg::COORD_W;
  localparam int unsigned DW   = psnd_pkg::DIFF_W;
  localparam int unsigned SUMW = psnd_pkg::PROD_W + 2;

  function automatic logic signed [CW-1:0] lerp(input logic signed [CW-1:0] a,
                                                input logic signed [psnd_pkg::PROD_W-1:0] p);
    logic signed [SUMW-1:0] s;
    logic signed [SUMW-1:0] q;
    s = (SUMW'(a) <<< psnd_pkg::T_FRAC) + SUMW'(p);
    q = s >>> psnd_pkg::T_FRAC;
    // round toward zero
    if (s[SUMW-1] && (s[psnd_pkg::T_FRAC-1:0] != '0)) q = q + SUMW'(1);
    return q[CW-1:0];
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : v;
  endfunction

  // config register
  logic [psnd_pkg::TOL_W-1:0] tol_q;
  logic                       wr_tol;

  assign pready = 1'b1;
  assign wr_tol = psel && penable && pwrite && (paddr[2] == psnd_pkg::REG_TOL);
  assign prdata = (paddr[2] == psnd_pkg::REG_TOL) ?
                  {{(psnd_pkg::PDATA_W-psnd_pkg::TOL_W){1'b0}}, tol_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (wr_tol) begin
      tol_q <= pwdata[psnd_pkg::TOL_W-1:0];
    end
  end

  // pipe control
  logic [NSTG-1:0] v_q;
  logic            adv;

  assign adv        = !v_q[NSTG-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-2:0], in_i.valid};
    end
  end

  // stage 1: differences
  logic signed [CW-1:0] px1_q, py1_q, ax1_q, ay1_q;
  logic signed [DW-1:0] dx1_q, dy1_q, wx1_q, wy1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px1_q <= in_i.point_x;
      py1_q <= in_i.point_y;
      ax1_q <= in_i.seg_a_x;
      ay1_q <= in_i.seg_a_y;
      dx1_q <= DW'(in_i.seg_b_x) - DW'(in_i.seg_a_x);
      dy1_q <= DW'(in_i.seg_b_y) - DW'(in_i.seg_a_y);
      wx1_q <= DW'(in_i.point_x) - DW'(in_i.seg_a_x);
      wy1_q <= DW'(in_i.point_y) - DW'(in_i.seg_a_y);
    end
  end

  // stage 2: products, degenerate test
  logic signed [psnd_pkg::PROD_W-1:0] pwx2_q, pwy2_q, ddx2_q, ddy2_q;
  logic                               degen2_q;
  psnd_pkg::geo_side_t                side2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pwx2_q   <= dx1_q * wx1_q;
      pwy2_q   <= dy1_q * wy1_q;
      ddx2_q   <= dx1_q * dx1_q;
      ddy2_q   <= dy1_q * dy1_q;
      degen2_q <= (mag(dx1_q) <= DW'(tol_q)) && (mag(dy1_q) <= DW'(tol_q));
      side2_q  <= '{px: px1_q, py: py1_q, ax: ax1_q, ay: ay1_q, dx: dx1_q, dy: dy1_q,
                    code: psnd_pkg::CASE_INTERIOR};
    end
  end

  // stage 3: projection numerator and denominator, classification
  logic signed [psnd_pkg::NUM_W-1:0] num2;
  logic        [psnd_pkg::DEN_W-1:0] den2;
  psnd_pkg::case_e                   code2;
  logic        [psnd_pkg::DEN_W-1:0] dnum3_q, den3_q;
  psnd_pkg::geo_side_t               side3_q;

  assign num2 = psnd_pkg::NUM_W'(pwx2_q) + psnd_pkg::NUM_W'(pwy2_q);
  assign den2 = ddx2_q[psnd_pkg::DEN_W-1:0] + ddy2_q[psnd_pkg::DEN_W-1:0];

  always_comb begin
    priority if (degen2_q) begin
      code2 = psnd_pkg::CASE_DEGEN;
    end else if (num2 >= $signed({1'b0, den2})) begin
      code2 = psnd_pkg::CASE_END;
    end else if (num2[psnd_pkg::NUM_W-1] || (num2 == '0)) begin
      code2 = psnd_pkg::CASE_START;
    end else begin
      code2 = psnd_pkg::CASE_INTERIOR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dnum3_q <= (code2 == psnd_pkg::CASE_INTERIOR) ?
                 num2[psnd_pkg::DEN_W-1:0] : '0;
      den3_q  <= den2;
      side3_q <= '{px: side2_q.px, py: side2_q.py, ax: side2_q.ax, ay: side2_q.ay,
                   dx: side2_q.dx, dy: side2_q.dy, code: code2};
    end
  end

  // divider with matching side delay
  logic [psnd_pkg::T_FRAC-1:0] tq;
  psnd_pkg::geo_side_t         dside_q [psnd_pkg::DIV_STAGES];

  psnd_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (dnum3_q),
    .den_i (den3_q),
    .quo_o (tq)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dside_q[0] <= side3_q;
      for (int i = 1; i < psnd_pkg::DIV_STAGES; i++) dside_q[i] <= dside_q[i-1];
    end
  end

  // stage 4: interpolation products
  logic signed [psnd_pkg::PROD_W-1:0] lx4_q, ly4_q;
  psnd_pkg::geo_side_t                side4_q;
  psnd_pkg::geo_side_t                dlast;

  assign dlast = dside_q[psnd_pkg::DIV_STAGES-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lx4_q   <= $signed({1'b0, tq}) * dlast.dx;
      ly4_q   <= $signed({1'b0, tq}) * dlast.dy;
      side4_q <= dlast;
    end
  end

  // stage 5: nearest point
  logic signed [DW-1:0] bx4, by4;
  logic signed [CW-1:0] nx4, ny4;
  logic signed [CW-1:0] nx5_q, ny5_q;
  psnd_pkg::geo_side_t  side5_q;

  assign bx4 = DW'(side4_q.ax) + side4_q.dx;
  assign by4 = DW'(side4_q.ay) + side4_q.dy;

  always_comb begin
    unique case (side4_q.code)
      psnd_pkg::CASE_INTERIOR: begin
        nx4 = lerp(side4_q.ax, lx4_q);
        ny4 = lerp(side4_q.ay, ly4_q);
      end
      psnd_pkg::CASE_END: begin
        nx4 = bx4[CW-1:0];
        ny4 = by4[CW-1:0];
      end
      default: begin
        nx4 = side4_q.ax;
        ny4 = side4_q.ay;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx5_q   <= nx4;
      ny5_q   <= ny4;
      side5_q <= side4_q;
    end
  end

  // stage 6: error vector
  logic signed [DW-1:0] ex6_q, ey6_q;
  psnd_pkg::near_side_t nside6_q, nside7_q, nside8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ex6_q    <= DW'(side5_q.px) - DW'(nx5_q);
      ey6_q    <= DW'(side5_q.py) - DW'(ny5_q);
      nside6_q <= '{nx: nx5_q, ny: ny5_q, code: side5_q.code};
    end
  end

  // stage 7, 8: squared distance
  logic signed [psnd_pkg::PROD_W-1:0] sqx7_q, sqy7_q;
  logic        [psnd_pkg::SQ_W-1:0]   sq8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx7_q   <= ex6_q * ex6_q;
      sqy7_q   <= ey6_q * ey6_q;
      nside7_q <= nside6_q;
      sq8_q    <= sqx7_q[psnd_pkg::SQ_W-1:0] + sqy7_q[psnd_pkg::SQ_W-1:0];
      nside8_q <= nside7_q;
    end
  end

  // root with matching side delay
  logic [psnd_pkg::DIST_W-1:0] root;
  psnd_pkg::near_side_t        sside_q [psnd_pkg::SQRT_STAGES];

  psnd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .sq_i   (sq8_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sside_q[0] <= nside8_q;
      for (int i = 1; i < psnd_pkg::SQRT_STAGES; i++) sside_q[i] <= sside_q[i-1];
    end
  end

  assign out_o.valid     = v_q[NSTG-1];
  assign out_o.near_x    = sside_q[psnd_pkg::SQRT_STAGES-1].nx;
  assign out_o.near_y    = sside_q[psnd_pkg::SQRT_STAGES-1].ny;
  assign out_o.case_code = sside_q[psnd_pkg::SQRT_STAGES-1].code;
  assign out_o.distance  = root;

  // interior items go into the divider with 0 < num < den
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S3] && (side3_q.code == psnd_pkg::CASE_INTERIOR) |->
      (dnum3_q != '0) && (dnum3_q < den3_q))
    else $error("divider operands out of range");

  // an interior item never has a zero-length segment after the divider
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S4] && (side4_q.code == psnd_pkg::CASE_INTERIOR) |->
      (side4_q.dx != '0) || (side4_q.dy != '0))
    else $error("interior item with zero-length segment");

  // interpolated x lies between the endpoints
  a_near_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S5] && (side5_q.code == psnd_pkg::CASE_INTERIOR) |->
      (((DW'(nx5_q) >= DW'(side5_q.ax)) &&
        (DW'(nx5_q) <= DW'(side5_q.ax) + side5_q.dx)) ||
       ((DW'(nx5_q) <= DW'(side5_q.ax)) &&
        (DW'(nx5_q) >= DW'(side5_q.ax) + side5_q.dx))))
    else $error("nearest point outside segment");

  a_stage7_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[S7] |-> (sqx7_q[psnd_pkg::PROD_W-1] == 1'b0) && (sqy7_q[psnd_pkg::PROD_W-1] == 1'b0))
    else $error("negative square");

endmodule
`default_nettype wire

@@ dv/tb_point_segment_nearest_distance.sv @@
module tb_point_segment_nearest_distance;

  typedef struct packed {
    logic signed [psnd_pkg::COORD_W-1:0] nx;
    logic signed [psnd_pkg::COORD_W-1:0] ny;
    logic [psnd_pkg::DIST_W-1:0]         distance;
    psnd_pkg::case_e                     code;
  } nearest_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [psnd_pkg::PADDR_W-1:0] paddr = '0;
  logic [psnd_pkg::PDATA_W-1:0] pwdata = '0;
  logic [psnd_pkg::PDATA_W-1:0] prdata;
  logic pready;

  psnd_in_if  qry ();
  psnd_out_if res ();

  point_segment_nearest_distance dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_i(qry.sink), .out_o(res.source)
  );

  always #2 clk_i = ~clk_i;

  logic [7:0] tol_q = '0;
  nearest_t   expected_q[$];
  int unsigned send_idle_pct = 0, recv_idle_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned mismatches = 0, checked = 0, sent = 0;
  int unsigned code_seen[4] = '{0, 0, 0, 0};

  initial begin
    qry.valid = 1'b0;
    qry.point_x = '0; qry.point_y = '0;
    qry.seg_a_x = '0; qry.seg_a_y = '0;
    qry.seg_b_x = '0; qry.seg_b_y = '0;
    res.ready = 1'b0;
  end

  function automatic logic [63:0] floor_root(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic nearest_t nearest_point(logic signed [15:0] px, logic signed [15:0] py,
                                             logic signed [15:0] ax, logic signed [15:0] ay,
                                             logic signed [15:0] bx, logic signed [15:0] by);
    longint dx, dy, wx, wy, num, den, tq, nx, ny, ex, ey, ad, bd;
    logic [63:0] root;
    nearest_t r;
    dx = longint'(bx) - longint'(ax);
    dy = longint'(by) - longint'(ay);
    wx = longint'(px) - longint'(ax);
    wy = longint'(py) - longint'(ay);
    ad = dx < 0 ? -dx : dx;
    bd = dy < 0 ? -dy : dy;
    if (ad <= longint'(tol_q) && bd <= longint'(tol_q)) begin
      nx = ax; ny = ay; r.code = psnd_pkg::CASE_DEGEN;
    end else begin
      num = dx * wx + dy * wy;
      den = dx * dx + dy * dy;
      if (num >= den) begin
        nx = bx; ny = by; r.code = psnd_pkg::CASE_END;
      end else if (num <= 0) begin
        nx = ax; ny = ay; r.code = psnd_pkg::CASE_START;
      end else begin
        tq = (num <<< psnd_pkg::T_FRAC) / den;
        // signed division truncates toward zero, as required
        nx = (longint'(ax) * (64'sd1 <<< psnd_pkg::T_FRAC) + tq * dx) /
             (64'sd1 <<< psnd_pkg::T_FRAC);
        ny = (longint'(ay) * (64'sd1 <<< psnd_pkg::T_FRAC) + tq * dy) /
             (64'sd1 <<< psnd_pkg::T_FRAC);
        r.code = psnd_pkg::CASE_INTERIOR;
      end
    end
    ex = longint'(px) - nx;
    ey = longint'(py) - ny;
    r.nx = nx[15:0];
    r.ny = ny[15:0];
    root = floor_root(ex * ex + ey * ey);
    r.distance = root[psnd_pkg::DIST_W-1:0];
    return r;
  endfunction

  task automatic write_tolerance(logic [7:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= psnd_pkg::PADDR_W'(psnd_pkg::REG_TOL) << 2; pwdata <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tol_q = v;
  endtask

  task automatic send_query(logic [15:0] px, logic [15:0] py, logic [15:0] ax,
                            logic [15:0] ay, logic [15:0] bx, logic [15:0] by);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      qry.valid <= 1'b0;
      @(posedge clk_i);
    end
    qry.valid <= 1'b1;
    qry.point_x <= px; qry.point_y <= py;
    qry.seg_a_x <= ax; qry.seg_a_y <= ay;
    qry.seg_b_x <= bx; qry.seg_b_y <= by;
    do @(posedge clk_i); while (!qry.ready);
    expected_q.push_back(nearest_point(px, py, ax, ay, bx, by));
    sent++;
  endtask

  task automatic drain_pipe();
    int unsigned n;
    qry.valid <= 1'b0;
    n = 0;
    while (expected_q.size() != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  // result side: random stall, long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        nearest_t e, a;
        a.nx = res.near_x; a.ny = res.near_y; a.distance = res.distance;
        a.code = psnd_pkg::case_e'(res.case_code);
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer %p", a);
        end else begin
          e = expected_q.pop_front();
          checked++;
          code_seen[e.code]++;
          if (a !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch exp %p got %p", e, a);
          end
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(512)) - 256);
      2: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3)) :
                                    16'h8000 + 16'($urandom_range(3));
      default: return 16'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  task automatic random_query();
    logic [15:0] ax, ay, bx, by;
    ax = rnd_coord(); ay = rnd_coord();
    if ($urandom_range(9) == 0) begin
      // near-degenerate segment around the tolerance boundary
      bx = ax + 16'($signed($urandom_range(2 * tol_q + 4)) - tol_q - 2);
      by = ay + 16'($signed($urandom_range(2 * tol_q + 4)) - tol_q - 2);
    end else begin
      bx = rnd_coord(); by = rnd_coord();
    end
    send_query(rnd_coord(), rnd_coord(), ax, ay, bx, by);
  endtask

  task automatic test_directed();
    write_tolerance(8'd0);
    send_query(16'h0080, 16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
    send_query(16'hff00, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
    send_query(16'h0300, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
    send_query(16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0100, 16'h0100);
    send_query(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
    send_query(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
    send_query(16'h1234, 16'h4321, 16'h0500, 16'h0600, 16'h0500, 16'h0600);
    send_query(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_query(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_query(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_query(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_query(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send_query(16'hffff, 16'h0003, 16'hfffe, 16'h0000, 16'h0001, 16'h0001);
    send_query(16'h0055, 16'h00aa, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
    drain_pipe();
    write_tolerance(8'hff);
    send_query(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h00ff, 16'hff01);
    send_query(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
    send_query(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'hff01, 16'h00ff);
    drain_pipe();
  endtask

  task automatic test_random(int unsigned n, int unsigned s_pct, int unsigned r_pct,
                             logic [7:0] tol);
    write_tolerance(tol);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) random_query();
    drain_pipe();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 300;
    repeat (120) random_query();
    drain_pipe();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(450, 36, 81, 8'd3);
    test_random(450, 81, 36, 8'd0);
    test_backpressure();
    test_random(330, 0, 0, 8'd255);
    $display("sent %0d queries, checked %0d results over tolerances 0, 3, 255", sent, checked);
    $display("cases: interior %0d, start %0d, end %0d, degenerate %0d",
             code_seen[0], code_seen[1], code_seen[2], code_seen[3]);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
